// ----- rtl/gyro_still_bias_calibrator_top_assert.svh -----
// Assertion macros for the gyro still bias calibrator.
// Used by the modules that assert; they need aclk and aresetn in scope.
`ifndef GYRO_STILL_BIAS_CALIBRATOR_TOP_ASSERT_SVH
`define GYRO_STILL_BIAS_CALIBRATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GSBC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gsbc assertion failed");
`define GSBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gsbc next-cycle assertion failed");
`else
`define GSBC_ASSERT(label, prop)
`define GSBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/gsbc_pkg.sv -----
// Types and constants shared by the gyro still bias calibrator modules.
// No dependencies.
package gsbc_pkg;

    localparam int RAW_W      = 16;
    localparam int RAW_EXT_W  = 24;
    localparam int THRESH_W   = 15;
    localparam int TICK_W     = 12;
    localparam int LIMIT_W    = 16;
    localparam int WEIGHT_W   = 24;
    localparam int BIAS_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_TICKS_NEEDED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_ACCEL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT        = 3'd4;

    localparam logic [THRESH_W-1:0] RST_STILL_THRESHOLD     = 15'd205;
    localparam logic [TICK_W-1:0]   RST_STILL_TICKS_NEEDED  = 12'd100;
    localparam logic [TICK_W-1:0]   RST_ACCUMULATE_TICKS    = 12'd400;
    localparam logic [LIMIT_W-1:0]  RST_LATERAL_ACCEL_LIMIT = 16'd50;
    localparam logic [WEIGHT_W-1:0] RST_BLEND_WEIGHT        = 24'd1678;

    typedef struct packed {
        logic signed [RAW_W-1:0] rate_x;
        logic signed [RAW_W-1:0] rate_y;
        logic signed [RAW_W-1:0] rate_z;
        logic signed [RAW_W-1:0] lin_accel_x;
        logic signed [RAW_W-1:0] lin_accel_y;
        logic                    in_flight;
        logic                    sticks_quiet;
    } in_item_t;

    typedef struct packed {
        logic                     rejected;
        logic                     never_rejected;
        logic                     accumulating;
        logic                     committed;
        logic signed [BIAS_W-1:0] bias_x;
        logic signed [BIAS_W-1:0] bias_y;
        logic signed [BIAS_W-1:0] bias_z;
    } out_item_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic             guard_fail;
        logic             still;
        logic [RAW_W-1:0] rate_x;
        logic [RAW_W-1:0] rate_y;
        logic [RAW_W-1:0] rate_z;
    } q_item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] still_threshold;
        logic [TICK_W-1:0]   still_ticks_needed;
        logic [TICK_W-1:0]   accumulate_ticks;
        logic [LIMIT_W-1:0]  lateral_accel_limit;
        logic [WEIGHT_W-1:0] blend_weight;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_MUL,
        ST_ADD
    } back_state_t;

endpackage

// ----- rtl/gsbc_front.sv -----
// Front end: accepts input items, applies the flight and lateral guard and
// the stillness test. Depends on gsbc_pkg.
module gsbc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  gsbc_pkg::in_item_t s_data,
    input  gsbc_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              q_push,
    output gsbc_pkg::q_item_t q_data
);
    import gsbc_pkg::*;

    localparam int MAG_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;

    logic [2:0][RAW_W-1:0]     raw;
    logic [2:0][RAW_EXT_W-1:0] raw_ext;
    logic signed [MAG_W-1:0]   rate_w [3];
    logic [MAG_W-1:0]          rate_mag [3];
    logic [2:0]                moving;
    logic [RAW_W:0]            ax_mag;
    logic [RAW_W:0]            ay_mag;
    logic [RAW_W:0]            lat_sum;
    logic                      still;

    assign raw = {s_data.rate_z, s_data.rate_y, s_data.rate_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // Only the low SAMPLE_BITS of the field carry the sample.
            raw_ext[i]  = {{(RAW_EXT_W-RAW_W){1'b0}}, raw[i]};
            rate_w[i]   = MAG_W'(signed'(raw_ext[i][SAMPLE_BITS-1:0]));
            rate_mag[i] = rate_w[i][MAG_W-1] ? MAG_W'(-rate_w[i]) : MAG_W'(rate_w[i]);
            moving[i]   = CMP_W'(rate_mag[i]) >= CMP_W'(cfg.still_threshold);
        end
    end

    assign still = ~|moving;

    assign ax_mag = s_data.lin_accel_x[RAW_W-1]
                  ? (RAW_W+1)'(-{s_data.lin_accel_x[RAW_W-1], s_data.lin_accel_x})
                  : (RAW_W+1)'({1'b0, s_data.lin_accel_x});
    assign ay_mag = s_data.lin_accel_y[RAW_W-1]
                  ? (RAW_W+1)'(-{s_data.lin_accel_y[RAW_W-1], s_data.lin_accel_y})
                  : (RAW_W+1)'({1'b0, s_data.lin_accel_y});
    assign lat_sum = ax_mag + ay_mag;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data.guard_fail = !s_data.in_flight || !s_data.sticks_quiet
                          || (lat_sum > {1'b0, cfg.lateral_accel_limit});
        q_data.still      = still;
        q_data.rate_x     = raw[0];
        q_data.rate_y     = raw[1];
        q_data.rate_z     = raw[2];
    end

endmodule

// ----- rtl/gsbc_queue.sv -----
// Short queue between the front end and the back end.
// Depends on gsbc_pkg.
module gsbc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  gsbc_pkg::q_item_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output gsbc_pkg::q_item_t pop_data
);
    import gsbc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign do_pop   = pop && q_valid;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/gsbc_back.sv -----
// Back end: phase and count state, per-axis sums, the commit divider and
// the bias blend, and the result register. Depends on gsbc_pkg and the
// assertion macro header.
`include "gyro_still_bias_calibrator_top_assert.svh"
module gsbc_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gsbc_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  gsbc_pkg::q_item_t   q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output gsbc_pkg::out_item_t m_data
);
    import gsbc_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_W  = SUM_W + FRAC_BITS + 1;
    localparam int BCNT_W = $clog2(NUM_W);
    localparam int CMP_W  = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
    localparam int DIFF_W = BIAS_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W;

    back_state_t            state_reg, state_next;
    logic                   phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  still_cnt_reg, still_cnt_next;
    logic [COUNT_BITS-1:0]  samp_cnt_reg, samp_cnt_next;
    logic                   clean_reg, clean_next;
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [BIAS_W-1:0] bias_reg [3];
    logic [NUM_W-1:0]       num_reg [3];
    logic [COUNT_BITS-1:0]  rem_reg [3];
    logic [2:0]             neg_reg;
    logic [COUNT_BITS-1:0]  den_reg;
    logic [BCNT_W-1:0]      bit_cnt_reg;
    logic signed [BIAS_W-1:0] mean_reg [3];
    logic [PROD_W-1:0]      prod_reg [3];
    logic [2:0]             pneg_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    // Item decode
    logic [2:0][RAW_W-1:0]     raw;
    logic [2:0][RAW_EXT_W-1:0] raw_ext;
    logic signed [SAMPLE_BITS-1:0] rate_s [3];
    logic signed [SUM_W-1:0]   sum_add [3];
    logic [SUM_W-1:0]          sum_mag [3];
    logic [COUNT_BITS-1:0]     still_inc;
    logic [COUNT_BITS-1:0]     samp_inc;
    logic [COUNT_BITS-1:0]     div_n;
    logic                      it_rej;
    logic                      it_commit;
    logic                      it_clear_sums;
    logic                      it_add_sums;
    logic                      it_phase;
    logic [COUNT_BITS-1:0]     it_still_cnt;
    logic [COUNT_BITS-1:0]     it_samp_cnt;

    // Arithmetic
    logic [COUNT_BITS:0]       trial [3];
    logic [COUNT_BITS:0]       trial_sub [3];
    logic [2:0]                trial_ge;
    logic signed [BIAS_W-1:0]  mean_sat [3];
    logic signed [DIFF_W-1:0]  diff [3];
    logic [DIFF_W-1:0]         diff_mag [3];
    logic [PROD_W-1:0]         prod_round [3];
    logic [DIFF_W-1:0]         delta_mag [3];
    logic [DIFF_W-1:0]         delta [3];
    logic signed [BIAS_W-1:0]  bias_new [3];

    // Control
    logic out_free;
    logic take_item;
    logic load_item_result;
    logic load_commit_result;

    assign out_free = !m_valid_reg || m_ready;
    assign raw      = {q_data.rate_z, q_data.rate_y, q_data.rate_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            raw_ext[i] = {{(RAW_EXT_W-RAW_W){1'b0}}, raw[i]};
            rate_s[i]  = signed'(raw_ext[i][SAMPLE_BITS-1:0]);
            sum_add[i] = sum_reg[i] + SUM_W'(rate_s[i]);
            sum_mag[i] = sum_add[i][SUM_W-1] ? SUM_W'(-sum_add[i]) : SUM_W'(sum_add[i]);
        end
    end

    assign still_inc = still_cnt_reg + 1'b1;
    assign samp_inc  = samp_cnt_reg + 1'b1;
    assign div_n     = (samp_inc == '0) ? COUNT_BITS'(1) : samp_inc;

    always_comb begin
        it_rej        = 1'b0;
        it_commit     = 1'b0;
        it_clear_sums = 1'b0;
        it_add_sums   = 1'b0;
        it_phase      = phase_reg;
        it_still_cnt  = still_cnt_reg;
        it_samp_cnt   = samp_cnt_reg;
        if (q_data.guard_fail) begin
            it_rej = 1'b1;
        end else if (!phase_reg) begin
            if (q_data.still) begin
                it_still_cnt = still_inc;
                if (CMP_W'(still_inc) >= CMP_W'(cfg.still_ticks_needed)) begin
                    it_phase      = 1'b1;
                    it_samp_cnt   = '0;
                    it_clear_sums = 1'b1;
                end
            end else begin
                it_still_cnt = '0;
            end
        end else if (q_data.still) begin
            it_add_sums = 1'b1;
            it_samp_cnt = samp_inc;
            if (CMP_W'(samp_inc) >= CMP_W'(cfg.accumulate_ticks)) begin
                it_commit    = 1'b1;
                it_phase     = 1'b0;
                it_still_cnt = '0;
                it_samp_cnt  = '0;
            end
        end else begin
            it_rej = 1'b1;
        end
        if (it_rej) begin
            it_phase     = 1'b0;
            it_still_cnt = '0;
            it_samp_cnt  = '0;
        end
    end

    // One quotient bit per lane per cycle, restoring division.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i]     = {rem_reg[i], num_reg[i][NUM_W-1]};
            trial_sub[i] = trial[i] - {1'b0, den_reg};
            trial_ge[i]  = trial[i] >= {1'b0, den_reg};
        end
    end

    // Saturate the quotient to the signed 32 bit range.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!neg_reg[i]) begin
                mean_sat[i] = (|num_reg[i][NUM_W-1:BIAS_W-1])
                            ? {1'b0, {(BIAS_W-1){1'b1}}}
                            : signed'(num_reg[i][BIAS_W-1:0]);
            end else if ((|num_reg[i][NUM_W-1:BIAS_W])
                         || (num_reg[i][BIAS_W-1] && |num_reg[i][BIAS_W-2:0])) begin
                mean_sat[i] = {1'b1, {(BIAS_W-1){1'b0}}};
            end else begin
                mean_sat[i] = signed'(-num_reg[i][BIAS_W-1:0]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]       = DIFF_W'(mean_reg[i]) - DIFF_W'(bias_reg[i]);
            diff_mag[i]   = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
            prod_round[i] = prod_reg[i] + (PROD_W'(1) << (WEIGHT_W - 1));
            delta_mag[i]  = prod_round[i][PROD_W-1:WEIGHT_W];
            delta[i]      = pneg_reg[i] ? DIFF_W'(-delta_mag[i]) : delta_mag[i];
            bias_new[i]   = bias_reg[i] + signed'(delta[i][BIAS_W-1:0]);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free && it_commit) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (bit_cnt_reg == BCNT_W'(NUM_W - 1)) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: state_next = ST_MUL;
            ST_MUL: state_next = ST_ADD;
            ST_ADD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        take_item          = 1'b0;
        load_commit_result = 1'b0;
        unique case (state_reg)
            ST_IDLE: take_item          = q_valid && out_free;
            ST_ADD:  load_commit_result = out_free;
            default: begin
                take_item          = 1'b0;
                load_commit_result = 1'b0;
            end
        endcase
    end

    assign q_pop            = take_item;
    assign load_item_result = take_item && !it_commit;

    always_comb begin
        phase_next     = phase_reg;
        still_cnt_next = still_cnt_reg;
        samp_cnt_next  = samp_cnt_reg;
        clean_next     = clean_reg;
        if (take_item) begin
            phase_next     = it_phase;
            still_cnt_next = it_still_cnt;
            samp_cnt_next  = it_samp_cnt;
            clean_next     = clean_reg && !it_rej;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            still_cnt_reg <= '0;
            samp_cnt_reg  <= '0;
            clean_reg     <= 1'b1;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            still_cnt_reg <= still_cnt_next;
            samp_cnt_reg  <= samp_cnt_next;
            clean_reg     <= clean_next;
            if (load_item_result || load_commit_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                if (take_item && (it_clear_sums || it_commit)) begin
                    sum_reg[i] <= '0;
                end else if (take_item && it_add_sums) begin
                    sum_reg[i] <= sum_add[i];
                end
                if (load_commit_result) begin
                    bias_reg[i] <= bias_new[i];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                bit_cnt_reg <= '0;
                den_reg     <= div_n;
                for (int i = 0; i < 3; i++) begin
                    num_reg[i] <= NUM_W'({sum_mag[i], {FRAC_BITS{1'b0}}})
                                + NUM_W'(div_n >> 1);
                    rem_reg[i] <= '0;
                    neg_reg[i] <= sum_add[i][SUM_W-1];
                end
            end
            ST_DIV: begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    num_reg[i] <= {num_reg[i][NUM_W-2:0], trial_ge[i]};
                    rem_reg[i] <= trial_ge[i] ? trial_sub[i][COUNT_BITS-1:0]
                                              : trial[i][COUNT_BITS-1:0];
                end
            end
            ST_SAT: begin
                for (int i = 0; i < 3; i++) begin
                    mean_reg[i] <= mean_sat[i];
                end
            end
            ST_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    prod_reg[i] <= PROD_W'(diff_mag[i]) * PROD_W'(cfg.blend_weight);
                    pneg_reg[i] <= diff[i][DIFF_W-1];
                end
            end
            default: begin
                bit_cnt_reg <= bit_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_item_result) begin
            m_data_reg.rejected       <= it_rej;
            m_data_reg.never_rejected <= clean_reg && !it_rej;
            m_data_reg.accumulating   <= it_phase;
            m_data_reg.committed      <= 1'b0;
            m_data_reg.bias_x         <= bias_reg[0];
            m_data_reg.bias_y         <= bias_reg[1];
            m_data_reg.bias_z         <= bias_reg[2];
        end else if (load_commit_result) begin
            m_data_reg.rejected       <= 1'b0;
            m_data_reg.never_rejected <= clean_reg;
            m_data_reg.accumulating   <= 1'b0;
            m_data_reg.committed      <= 1'b1;
            m_data_reg.bias_x         <= bias_new[0];
            m_data_reg.bias_y         <= bias_new[1];
            m_data_reg.bias_z         <= bias_new[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GSBC_ASSERT(a_commit_leaves_waiting, m_valid_reg && m_data_reg.committed |-> !m_data_reg.accumulating && !m_data_reg.rejected)
    `GSBC_ASSERT(a_reject_clears_clean, m_valid_reg && m_data_reg.rejected |-> !m_data_reg.never_rejected && !clean_reg)
    `GSBC_ASSERT_NEXT(a_div_runs_to_sat, state_reg == ST_DIV, state_reg == ST_DIV || state_reg == ST_SAT)
    `GSBC_ASSERT(a_pop_only_idle, q_pop |-> state_reg == ST_IDLE && out_free)

endmodule

// ----- rtl/gyro_still_bias_calibrator_top.sv -----
// Top level of the gyro still bias calibrator: configuration registers and
// the front end, queue and back end. Depends on gsbc_pkg and the gsbc modules.
//
//  Channel   Ports                          Moves
//  input     s_valid s_ready s_data         one sample tick per item
//  result    m_valid m_ready m_data         one result item per tick
//  config    cfg_wr_en cfg_wr_index/data    register write, no wait
//
// An ordinary tick passes the queue entry and then the result register; the
// back end handles one tick per cycle while idle with the result register
// free. A committing tick holds the back end through the bit-serial divider,
// which forms the three means in parallel, then the saturate, multiply and
// add states. The two-entry queue accepts until full while the back end is
// busy or the result waits. Reset is synchronous, active low, no clearing pass.
module gyro_still_bias_calibrator_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gsbc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gsbc_pkg::out_item_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [gsbc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [gsbc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import gsbc_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    q_full;
    logic    q_push;
    q_item_t q_push_data;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_STILL_THRESHOLD:
                    cfg_next.still_threshold = cfg_wr_data[THRESH_W-1:0];
                CFG_STILL_TICKS_NEEDED:
                    cfg_next.still_ticks_needed = cfg_wr_data[TICK_W-1:0];
                CFG_ACCUMULATE_TICKS:
                    cfg_next.accumulate_ticks = cfg_wr_data[TICK_W-1:0];
                CFG_LATERAL_ACCEL_LIMIT:
                    cfg_next.lateral_accel_limit = cfg_wr_data[LIMIT_W-1:0];
                CFG_BLEND_WEIGHT:
                    cfg_next.blend_weight = cfg_wr_data[WEIGHT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.still_threshold     <= RST_STILL_THRESHOLD;
            cfg_reg.still_ticks_needed  <= RST_STILL_TICKS_NEEDED;
            cfg_reg.accumulate_ticks    <= RST_ACCUMULATE_TICKS;
            cfg_reg.lateral_accel_limit <= RST_LATERAL_ACCEL_LIMIT;
            cfg_reg.blend_weight        <= RST_BLEND_WEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gsbc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    gsbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_data  (q_pop_data)
    );

    gsbc_back #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- tb/gyro_still_bias_calibrator_top_tb.sv -----
// Self-checking testbench for the gyro still bias calibrator top level.
// Depends on gsbc_pkg and the RTL; predicts each result item and compares it.
`timescale 1ns / 100ps

module gyro_still_bias_calibrator_top_tb;
    import gsbc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 20000;
    localparam int IN_W        = $bits(in_item_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    gyro_still_bias_calibrator_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Predictor state and register copies.
    logic [THRESH_W-1:0] p_thresh;
    logic [TICK_W-1:0]   p_still_need;
    logic [TICK_W-1:0]   p_acc_need;
    logic [LIMIT_W-1:0]  p_lat_limit;
    logic [WEIGHT_W-1:0] p_weight;
    logic                p_accumulating;
    logic [TICK_W-1:0]   p_still_cnt;
    logic [TICK_W-1:0]   p_sample_cnt;
    longint              p_sum [3];
    logic signed [31:0]  p_bias [3];
    logic                p_clean;

    out_item_t expected_results[$];
    int  failures = 0;
    int  idle_pct = 34;
    bit  hold_receiver = 0;
    int  quiet_cycles = 0;

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic out_item_t predict_tick(in_item_t t);
        out_item_t r;
        longint rate [3];
        longint lat, mean, diff;
        bit still, rej, com;
        rej = 0;
        com = 0;
        still = 1;
        rate[0] = t.rate_x;
        rate[1] = t.rate_y;
        rate[2] = t.rate_z;
        lat = ((t.lin_accel_x < 0) ? -longint'(t.lin_accel_x) : longint'(t.lin_accel_x))
            + ((t.lin_accel_y < 0) ? -longint'(t.lin_accel_y) : longint'(t.lin_accel_y));
        if (!t.in_flight || !t.sticks_quiet || lat > longint'(p_lat_limit)) begin
            rej = 1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (((rate[i] < 0) ? -rate[i] : rate[i]) >= longint'(p_thresh)) still = 0;
            end
            if (!p_accumulating) begin
                if (still) begin
                    p_still_cnt = p_still_cnt + 1'b1;
                    if (p_still_cnt >= p_still_need) begin
                        p_accumulating = 1;
                        p_sample_cnt = '0;
                        for (int i = 0; i < 3; i++) p_sum[i] = 0;
                    end
                end else begin
                    p_still_cnt = '0;
                end
            end else if (still) begin
                for (int i = 0; i < 3; i++) p_sum[i] += rate[i];
                p_sample_cnt = p_sample_cnt + 1'b1;
                if (p_sample_cnt >= p_acc_need) begin
                    for (int i = 0; i < 3; i++) begin
                        mean = round_div(p_sum[i] * 65536,
                                         (p_sample_cnt == 0) ? 1 : longint'(p_sample_cnt));
                        if (mean > 64'sd2147483647) mean = 64'sd2147483647;
                        if (mean < -64'sd2147483648) mean = -64'sd2147483648;
                        diff = mean - longint'(p_bias[i]);
                        p_bias[i] = 32'(longint'(p_bias[i])
                                   + round_div(diff * longint'(p_weight), 64'd16777216));
                        p_sum[i] = 0;
                    end
                    com = 1;
                    p_accumulating = 0;
                    p_still_cnt = '0;
                    p_sample_cnt = '0;
                end
            end else begin
                rej = 1;
            end
        end
        if (rej) begin
            p_accumulating = 0;
            p_still_cnt = '0;
            p_sample_cnt = '0;
            p_clean = 0;
        end
        r.rejected = rej;
        r.never_rejected = p_clean;
        r.accumulating = p_accumulating;
        r.committed = com;
        r.bias_x = p_bias[0];
        r.bias_y = p_bias[1];
        r.bias_z = p_bias[2];
        return r;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_STILL_THRESHOLD:     p_thresh = val[THRESH_W-1:0];
            CFG_STILL_TICKS_NEEDED:  p_still_need = val[TICK_W-1:0];
            CFG_ACCUMULATE_TICKS:    p_acc_need = val[TICK_W-1:0];
            CFG_LATERAL_ACCEL_LIMIT: p_lat_limit = val[LIMIT_W-1:0];
            CFG_BLEND_WEIGHT:        p_weight = val[WEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send_tick(input in_item_t t);
        bit ready_seen;
        // Valid is raised by this call; the previous item may leave it high.
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            if (s_valid) s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        // Ready is sampled mid-cycle, where it holds the value seen at the next edge.
        do begin
            @(negedge aclk);
            ready_seen = s_ready;
            @(posedge aclk);
        end while (!ready_seen);
        expected_results.push_back(predict_tick(t));
    endtask

    task automatic end_send();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic in_item_t calm_tick(int amp);
        in_item_t t;
        t.rate_x = 16'($signed($urandom_range(2 * amp)) - amp);
        t.rate_y = 16'($signed($urandom_range(2 * amp)) - amp);
        t.rate_z = 16'($signed($urandom_range(2 * amp)) - amp);
        t.lin_accel_x = 16'($signed($urandom_range(40)) - 20);
        t.lin_accel_y = 16'($signed($urandom_range(20)) - 10);
        t.in_flight = 1'b1;
        t.sticks_quiet = 1'b1;
        return t;
    endfunction

    function automatic in_item_t noise_tick();
        in_item_t t;
        t = in_item_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
        return t;
    endfunction

    task automatic test_directed_extremes();
        in_item_t t;
        write_register(CFG_STILL_THRESHOLD, 32767);
        write_register(CFG_STILL_TICKS_NEEDED, 0);
        write_register(CFG_ACCUMULATE_TICKS, 2);
        write_register(CFG_LATERAL_ACCEL_LIMIT, 65535);
        write_register(CFG_BLEND_WEIGHT, 24'hFFFFFF);
        t = '{rate_x: 16'sh7FFF, rate_y: 16'sh7FFF, rate_z: 16'sh7FFF,
              lin_accel_x: 16'sh8000, lin_accel_y: 16'sh8000, in_flight: 1, sticks_quiet: 1};
        send_tick(t);
        t.rate_x = 16'sh8001; t.rate_y = 16'sh8001; t.rate_z = 16'sh8001;
        send_tick(t); send_tick(t); send_tick(t);
        t.rate_x = 16'sh8000;
        send_tick(t);
        t.in_flight = 0; send_tick(t);
        t.in_flight = 1; t.sticks_quiet = 0; send_tick(t);
        t = '{rate_x: 16'sh7FFE, rate_y: 0, rate_z: 16'sh8002,
              lin_accel_x: 16'sh7FFF, lin_accel_y: 16'sh7FFF, in_flight: 1, sticks_quiet: 1};
        repeat (3) send_tick(t);
        end_send();
        wait_drained();
        // Accel sum exactly at the limit passes; one above rejects. Zero threshold.
        write_register(CFG_LATERAL_ACCEL_LIMIT, 30);
        write_register(CFG_STILL_THRESHOLD, 0);
        t = '{rate_x: 0, rate_y: 0, rate_z: 0,
              lin_accel_x: -16'sd10, lin_accel_y: 16'sd20, in_flight: 1, sticks_quiet: 1};
        send_tick(t);
        t.lin_accel_y = 16'sd21; send_tick(t);
        end_send();
        wait_drained();
        write_register(CFG_STILL_THRESHOLD, 5);
        t.lin_accel_y = 0;
        t.rate_x = 16'sd4; send_tick(t);
        t.rate_x = 16'sd5; send_tick(t);
        t.rate_x = -16'sd4; send_tick(t); send_tick(t);
        t.rate_z = 16'sd9; send_tick(t);
        end_send();
        wait_drained();
    endtask

    task automatic test_random_calibration(int rounds, int amp);
        int kind;
        for (int n = 0; n < rounds; n++) begin
            kind = $urandom_range(99);
            if (kind < 75) send_tick(calm_tick(amp));
            else if (kind < 88) send_tick(calm_tick(amp * 3 + 2));
            else send_tick(noise_tick());
        end
        end_send();
    endtask

    task automatic test_backpressure();
        hold_receiver = 1;
        for (int n = 0; n < 40; n++) send_tick(calm_tick(6));
        end_send();
        wait_drained();
    endtask

    // Receiver: random ready, with a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_receiver) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_receiver) begin
                repeat (300) @(posedge aclk);
                hold_receiver = 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                failures++;
            end else begin
                out_item_t e;
                e = expected_results.pop_front();
                if (e !== m_data) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("gyro_still_bias_calibrator_top verification failed");
            $finish;
        end
    end

    initial begin
        p_thresh = RST_STILL_THRESHOLD;
        p_still_need = RST_STILL_TICKS_NEEDED;
        p_acc_need = RST_ACCUMULATE_TICKS;
        p_lat_limit = RST_LATERAL_ACCEL_LIMIT;
        p_weight = RST_BLEND_WEIGHT;
        p_accumulating = 0;
        p_still_cnt = '0;
        p_sample_cnt = '0;
        p_clean = 1;
        for (int i = 0; i < 3; i++) begin
            p_sum[i] = 0;
            p_bias[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();

        write_register(CFG_STILL_THRESHOLD, 400);
        write_register(CFG_STILL_TICKS_NEEDED, 3);
        write_register(CFG_ACCUMULATE_TICKS, 5);
        write_register(CFG_LATERAL_ACCEL_LIMIT, 50);
        write_register(CFG_BLEND_WEIGHT, 4000000);
        test_random_calibration(450, 150);
        wait_drained();

        test_backpressure();

        write_register(CFG_STILL_THRESHOLD, 32767);
        write_register(CFG_STILL_TICKS_NEEDED, 1);
        write_register(CFG_ACCUMULATE_TICKS, 1);
        write_register(CFG_BLEND_WEIGHT, 24'hFFFFFF);
        idle_pct = 0;
        test_random_calibration(300, 32767);
        wait_drained();

        idle_pct = 34;
        write_register(CFG_STILL_THRESHOLD, 205);
        write_register(CFG_STILL_TICKS_NEEDED, 2);
        write_register(CFG_ACCUMULATE_TICKS, 12);
        write_register(CFG_BLEND_WEIGHT, 1678);
        test_random_calibration(400, 100);
        wait_drained();

        // Long run with the largest count registers; the run is too short for any item to reach them.
        write_register(CFG_STILL_TICKS_NEEDED, 4095);
        write_register(CFG_ACCUMULATE_TICKS, 4095);
        write_register(CFG_STILL_THRESHOLD, 32767);
        test_random_calibration(250, 200);
        wait_drained();

        if (failures == 0) begin
            $display("gyro_still_bias_calibrator_top verification clean");
        end else begin
            $display("gyro_still_bias_calibrator_top verification failed");
        end
        $finish;
    end

endmodule

// ----- gyro_still_bias_calibrator_top.f -----
+incdir+rtl
rtl/gsbc_pkg.sv
rtl/gsbc_front.sv
rtl/gsbc_queue.sv
rtl/gsbc_back.sv
rtl/gyro_still_bias_calibrator_top.sv
tb/gyro_still_bias_calibrator_top_tb.sv
